/* design/tpt_pkg.sv */
// ----------------------------------------------------------------------------
// tpt_pkg
// Shared types and constants of the touch point tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

    localparam int MAX_FINGERS_DEF = 16;
    localparam int COORD_BITS_DEF  = 16;
    localparam int ID_BITS         = 4;
    localparam int ID_SPACE        = 1 << ID_BITS;
    localparam int COUNT_BITS      = 5;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_BEGIN  = 2'd1,
        ST_UPDATE = 2'd2,
        ST_END    = 2'd3
    } touch_state_t;

    typedef enum logic [1:0] {
        ACT_DOWN  = 2'd0,
        ACT_UP    = 2'd1,
        ACT_MOVE  = 2'd2,
        ACT_OTHER = 2'd3
    } action_t;

    typedef struct packed {
        touch_state_t touch_state;
        logic         multi_finger;
        logic         accepted;
    } tpt_flags_t;

endpackage

`default_nettype wire

/* design/tpt_in_reg.sv */
// ----------------------------------------------------------------------------
// tpt_in_reg
// Input register: captures one request and holds it until the table stage
// takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_in_reg
    import tpt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ID_BITS-1:0]    s_finger_id,
    input  wire logic [COORD_BITS-1:0] s_x_pos,
    input  wire logic [COORD_BITS-1:0] s_y_pos,
    input  wire logic [1:0]            s_action,
    input  wire logic                  stg_take,
    output logic                       stg_valid,
    output logic [ID_BITS-1:0]         stg_finger_id,
    output logic [COORD_BITS-1:0]      stg_x_pos,
    output logic [COORD_BITS-1:0]      stg_y_pos,
    output logic [1:0]                 stg_action
);

    logic                  valid_reg, valid_next;
    logic [ID_BITS-1:0]    id_reg;
    logic [COORD_BITS-1:0] x_reg;
    logic [COORD_BITS-1:0] y_reg;
    logic [1:0]            action_reg;
    logic                  load;

    assign s_ready = !valid_reg || stg_take;
    assign load    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (stg_take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            id_reg     <= s_finger_id;
            x_reg      <= s_x_pos;
            y_reg      <= s_y_pos;
            action_reg <= s_action;
        end
    end

    assign stg_valid     = valid_reg;
    assign stg_finger_id = id_reg;
    assign stg_x_pos     = x_reg;
    assign stg_y_pos     = y_reg;
    assign stg_action    = action_reg;

endmodule

`default_nettype wire

/* design/tpt_table.sv */
// ----------------------------------------------------------------------------
// tpt_table
// Finger table with one read-modify-write per request; produces the result
// fields from the stored entry and the incoming request.
// ----------------------------------------------------------------------------
`default_nettype none

module tpt_table
    import tpt_pkg::*;
#(
    parameter int MAX_FINGERS = MAX_FINGERS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  ev_fire,
    input  wire logic [ID_BITS-1:0]    ev_finger_id,
    input  wire logic [COORD_BITS-1:0] ev_x_pos,
    input  wire logic [COORD_BITS-1:0] ev_y_pos,
    input  wire logic [1:0]            ev_action,
    output tpt_flags_t                 res_flags,
    output logic signed [COORD_BITS:0] res_delta_x,
    output logic signed [COORD_BITS:0] res_delta_y,
    output logic signed [COORD_BITS:0] res_dist_x,
    output logic signed [COORD_BITS:0] res_dist_y,
    output logic [COORD_BITS-1:0]      res_primary_start_x,
    output logic [COORD_BITS-1:0]      res_primary_start_y
);

    localparam int DEPTH = (MAX_FINGERS < ID_SPACE) ? MAX_FINGERS : ID_SPACE;
    localparam int IDX_W = $clog2(DEPTH);

    logic [DEPTH-1:0]      valid_reg;
    logic [COORD_BITS-1:0] start_x_reg [DEPTH];
    logic [COORD_BITS-1:0] start_y_reg [DEPTH];
    logic [COORD_BITS-1:0] cur_x_reg   [DEPTH];
    logic [COORD_BITS-1:0] cur_y_reg   [DEPTH];
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  multi_reg, multi_next;
    touch_state_t          state_reg, state_next;

    logic                  in_range;
    logic [IDX_W-1:0]      idx;
    logic                  hit;
    logic                  create;
    logic                  acc;
    logic                  is_down;
    logic                  id_zero;

    assign id_zero  = (ev_finger_id == '0);
    assign is_down  = (action_t'(ev_action) == ACT_DOWN);
    assign in_range = ({1'b0, ev_finger_id} < (ID_BITS + 1)'(DEPTH));
    assign idx      = ev_finger_id[IDX_W-1:0];
    assign hit      = in_range && valid_reg[idx];
    assign create   = in_range && !valid_reg[idx] && (!id_zero || is_down);
    assign acc      = hit || create;

    always_comb begin
        count_next = count_reg;
        if (create && count_reg != COUNT_MAX) begin
            count_next = count_reg + COUNT_BITS'(1);
        end
        multi_next = multi_reg || (create && !id_zero);
        state_next = state_reg;
        if (acc) begin
            if (id_zero && is_down) begin
                state_next = ST_BEGIN;
            end else if (action_t'(ev_action) == ACT_UP
                         && count_next == COUNT_BITS'(1)) begin
                state_next = ST_END;
            end else begin
                state_next = ST_UPDATE;
            end
        end
    end

    always_comb begin
        res_flags.touch_state  = state_next;
        res_flags.multi_finger = multi_next;
        res_flags.accepted     = acc;
        res_delta_x = '0;
        res_delta_y = '0;
        res_dist_x  = '0;
        res_dist_y  = '0;
        if (hit) begin
            res_delta_x = {1'b0, ev_x_pos} - {1'b0, cur_x_reg[idx]};
            res_delta_y = {1'b0, ev_y_pos} - {1'b0, cur_y_reg[idx]};
            res_dist_x  = {1'b0, ev_x_pos} - {1'b0, start_x_reg[idx]};
            res_dist_y  = {1'b0, ev_y_pos} - {1'b0, start_y_reg[idx]};
        end
        res_primary_start_x = '0;
        res_primary_start_y = '0;
        if (valid_reg[0]) begin
            res_primary_start_x = start_x_reg[0];
            res_primary_start_y = start_y_reg[0];
        end else if (create && id_zero) begin
            res_primary_start_x = ev_x_pos;
            res_primary_start_y = ev_y_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            count_reg <= '0;
            multi_reg <= 1'b0;
            state_reg <= ST_NONE;
        end else if (ev_fire) begin
            if (create) begin
                valid_reg[idx] <= 1'b1;
            end
            count_reg <= count_next;
            multi_reg <= multi_next;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_fire && hit) begin
            cur_x_reg[idx] <= ev_x_pos;
            cur_y_reg[idx] <= ev_y_pos;
        end else if (ev_fire && create) begin
            start_x_reg[idx] <= ev_x_pos;
            start_y_reg[idx] <= ev_y_pos;
            cur_x_reg[idx]   <= ev_x_pos;
            cur_y_reg[idx]   <= ev_y_pos;
        end
    end

endmodule

`default_nettype wire

/* design/touch_point_tracker_top.sv */
// Latency: m_valid rises at the clock edge after the one that accepts the
// request, when the result register is free.
// Throughput: one request per cycle while m_ready is high, set by the single
// read-modify-write of the finger table between the input and result registers.
// Reset: synchronous active-low aresetn clears the finger valid bits,
// the finger count, the multi-touch flag and the gesture state (none).
// ----------------------------------------------------------------------------
// touch_point_tracker_top
// Multi-finger touch point tracker: input register, finger table stage and
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_point_tracker_top
    import tpt_pkg::*;
#(
    parameter int MAX_FINGERS = MAX_FINGERS_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic [ID_BITS-1:0]    s_finger_id,
    input  wire logic [COORD_BITS-1:0] s_x_pos,
    input  wire logic [COORD_BITS-1:0] s_y_pos,
    input  wire logic [1:0]            s_action,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [1:0]                 m_touch_state,
    output logic                       m_multi_finger,
    output logic                       m_accepted,
    output logic signed [COORD_BITS:0] m_delta_x,
    output logic signed [COORD_BITS:0] m_delta_y,
    output logic signed [COORD_BITS:0] m_dist_x,
    output logic signed [COORD_BITS:0] m_dist_y,
    output logic [COORD_BITS-1:0]      m_primary_start_x,
    output logic [COORD_BITS-1:0]      m_primary_start_y
);

    logic                  stg_valid;
    logic [ID_BITS-1:0]    stg_finger_id;
    logic [COORD_BITS-1:0] stg_x_pos;
    logic [COORD_BITS-1:0] stg_y_pos;
    logic [1:0]            stg_action;
    logic                  out_free;
    logic                  fire;

    tpt_flags_t                 res_flags;
    logic signed [COORD_BITS:0] res_delta_x;
    logic signed [COORD_BITS:0] res_delta_y;
    logic signed [COORD_BITS:0] res_dist_x;
    logic signed [COORD_BITS:0] res_dist_y;
    logic [COORD_BITS-1:0]      res_primary_start_x;
    logic [COORD_BITS-1:0]      res_primary_start_y;

    logic                       m_valid_reg, m_valid_next;
    tpt_flags_t                 flags_reg;
    logic signed [COORD_BITS:0] delta_x_reg;
    logic signed [COORD_BITS:0] delta_y_reg;
    logic signed [COORD_BITS:0] dist_x_reg;
    logic signed [COORD_BITS:0] dist_y_reg;
    logic [COORD_BITS-1:0]      pstart_x_reg;
    logic [COORD_BITS-1:0]      pstart_y_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = stg_valid && out_free;

    tpt_in_reg #(
        .COORD_BITS (COORD_BITS)
    ) u_in_reg (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_finger_id   (s_finger_id),
        .s_x_pos       (s_x_pos),
        .s_y_pos       (s_y_pos),
        .s_action      (s_action),
        .stg_take      (fire),
        .stg_valid     (stg_valid),
        .stg_finger_id (stg_finger_id),
        .stg_x_pos     (stg_x_pos),
        .stg_y_pos     (stg_y_pos),
        .stg_action    (stg_action)
    );

    tpt_table #(
        .MAX_FINGERS (MAX_FINGERS),
        .COORD_BITS  (COORD_BITS)
    ) u_table (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .ev_fire             (fire),
        .ev_finger_id        (stg_finger_id),
        .ev_x_pos            (stg_x_pos),
        .ev_y_pos            (stg_y_pos),
        .ev_action           (stg_action),
        .res_flags           (res_flags),
        .res_delta_x         (res_delta_x),
        .res_delta_y         (res_delta_y),
        .res_dist_x          (res_dist_x),
        .res_dist_y          (res_dist_y),
        .res_primary_start_x (res_primary_start_x),
        .res_primary_start_y (res_primary_start_y)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            flags_reg    <= res_flags;
            delta_x_reg  <= res_delta_x;
            delta_y_reg  <= res_delta_y;
            dist_x_reg   <= res_dist_x;
            dist_y_reg   <= res_dist_y;
            pstart_x_reg <= res_primary_start_x;
            pstart_y_reg <= res_primary_start_y;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_touch_state     = flags_reg.touch_state;
    assign m_multi_finger    = flags_reg.multi_finger;
    assign m_accepted        = flags_reg.accepted;
    assign m_delta_x         = delta_x_reg;
    assign m_delta_y         = delta_y_reg;
    assign m_dist_x          = dist_x_reg;
    assign m_dist_y          = dist_y_reg;
    assign m_primary_start_x = pstart_x_reg;
    assign m_primary_start_y = pstart_y_reg;

    a_accept_has_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> touch_state_t'(m_touch_state) != ST_NONE)
        else $error("accepted request reports no gesture state");

    a_discard_no_motion: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_accepted |->
            m_delta_x == '0 && m_delta_y == '0 && m_dist_x == '0 && m_dist_y == '0)
        else $error("discarded request reports motion");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> stg_valid && m_valid && !m_ready)
        else $error("input stalled while a stage is free");

endmodule

`default_nettype wire
